// ===== hw/rtl/iiea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiea_pkg
// Shared types and codes for the indexed insert/erase array.
// ----------------------------------------------------------------------------
package iiea_pkg;

  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_INSERT = 2'd2;
  localparam logic [1:0] REQ_ERASE  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [1:0]               status;
    logic [IDX_W-1:0]         count;
    logic                     is_empty;
  } out_word_t;

  // broadcast to every cell
  typedef struct packed {
    logic               ins;
    logic               ers;
    logic               wr;
    logic               cap;
    logic [IDX_W-1:0]   pos;
    logic [DATA_W-1:0]  word;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_SHIFT
  } state_t;

endpackage

// ===== hw/rtl/iiea_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiea_cell
// One array position: element register plus a read tap that shifts toward
// position zero.
// ----------------------------------------------------------------------------
module iiea_cell import iiea_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] prev_elem,
  input  logic [DATA_W-1:0] next_elem,
  input  logic [DATA_W-1:0] next_tap,
  output logic [DATA_W-1:0] elem,
  output logic [DATA_W-1:0] tap
);

  localparam bit IN_RANGE = (IDX < (2 ** IDX_W));

  logic [DATA_W-1:0] elem_r, elem_nxt;
  logic [DATA_W-1:0] tap_r, tap_nxt;
  logic              at_pos;
  logic              above;

  assign at_pos = IN_RANGE && (ctl.pos == IDX_W'(IDX));
  assign above  = !IN_RANGE || (ctl.pos < IDX_W'(IDX));

  always_comb begin
    elem_nxt = elem_r;
    if (ctl.ins) begin
      if (above) begin
        elem_nxt = prev_elem;
      end else if (at_pos) begin
        elem_nxt = ctl.word;
      end
    end else if (ctl.ers) begin
      if (above || at_pos) begin
        elem_nxt = next_elem;
      end
    end else if (ctl.wr && at_pos) begin
      elem_nxt = ctl.word;
    end
  end

  assign tap_nxt = ctl.cap ? elem_r : next_tap;

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    tap_r  <= tap_nxt;
  end

  assign elem = elem_r;
  assign tap  = tap_r;

endmodule

// ===== hw/rtl/indexed_insert_erase_array.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_erase_array
// Ordered list of up to CAPACITY signed words held in a row of cells, with
// read, overwrite, insert-before and erase-at requests by index.
// ----------------------------------------------------------------------------
// Overwrite, insert, erase and any request with a bad index need no shift
// phase: every cell shifts or loads in parallel and the result word is
// registered at acceptance. A good read captures all elements into a tap
// line that moves one position toward cell zero per cycle; the block stays
// busy until element k reaches cell zero and is registered. A new word is
// taken only when the result register is empty or drained in that cycle.
module indexed_insert_erase_array import iiea_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic             acc;
  logic [CMPW-1:0]  pos_x, cnt_x;
  logic             good, full;
  logic             emit_rd;
  cell_ctl_t        ctl;

  logic [DATA_W-1:0] elem [CAPACITY];
  logic [DATA_W-1:0] tap  [CAPACITY];

  assign pos_x = CMPW'(in_data.index);
  assign cnt_x = CMPW'(count_r);
  assign full  = (count_r == CW'(CAPACITY));
  assign good  = (in_data.req_type == REQ_INSERT) ? (pos_x <= cnt_x) : (pos_x < cnt_x);

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign emit_rd  = (state_r == S_SHIFT) && (cnt_r == '0);

  always_comb begin
    ctl.ins  = acc && good && (in_data.req_type == REQ_INSERT) && !full;
    ctl.ers  = acc && good && (in_data.req_type == REQ_ERASE);
    ctl.wr   = acc && good && (in_data.req_type == REQ_WRITE);
    ctl.cap  = acc && good && (in_data.req_type == REQ_READ);
    ctl.pos  = in_data.index;
    ctl.word = in_data.write_data;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] prev_e, next_e, next_t;
    if (g == 0) begin : g_first
      assign prev_e = in_data.write_data;
    end else begin : g_mid
      assign prev_e = elem[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_e = '0;
      assign next_t = '0;
    end else begin : g_inner
      assign next_e = elem[g+1];
      assign next_t = tap[g+1];
    end
    iiea_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_elem (prev_e),
      .next_elem (next_e),
      .next_tap  (next_t),
      .elem      (elem[g]),
      .tap       (tap[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.cap) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (emit_rd) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.ins) begin
          count_nxt = count_r + CW'(1);
        end else if (ctl.ers) begin
          count_nxt = count_r - CW'(1);
        end
        if (ctl.cap) begin
          cnt_nxt = in_data.index;
        end else if (acc) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = good ? '0 : '1;
          out_data_nxt.status    = !good ? ST_RANGE
                                 : ((in_data.req_type == REQ_INSERT) && full) ? ST_FULL
                                 : ST_DONE;
          out_data_nxt.count     = IDX_W'(count_nxt);
          out_data_nxt.is_empty  = (count_nxt == '0);
        end
      end
      S_SHIFT: begin
        if (emit_rd) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = tap[0];
          out_data_nxt.status    = ST_DONE;
          out_data_nxt.count     = IDX_W'(count_r);
          out_data_nxt.is_empty  = (count_r == '0);
        end else begin
          cnt_nxt = cnt_r - IDX_W'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
